[src/lrsp_pkg.sv]
package lrsp_pkg;

  // Row geometry.
  localparam int unsigned ROW_WIDTH = 320;
  localparam int unsigned ROW_COUNT = 3;
  localparam int unsigned COL_W     = 9;
  localparam int unsigned ROW_W     = 2;
  localparam int unsigned CENTER    = ROW_WIDTH / 2;

  // Error scaling: error = offset_sum * 65536 / 1000, rounded. It is formed as
  // (|offset_sum| * 8192 + 62) / 125 by a 28-bit reciprocal and a 34-bit shift.
  localparam int unsigned ERR_ROUND = 62;
  localparam logic [27:0] ERR_RECIP = 28'd137438954;
  localparam int unsigned ERR_SHIFT = 34;

  // Interval divider widths.
  localparam int unsigned DIVD_W = 40;
  localparam int unsigned DIVS_W = 16;

  // Configuration port widths.
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_AW-1:0] {
    CFG_GAIN_P          = 3'd0,
    CFG_GAIN_I          = 3'd1,
    CFG_GAIN_D          = 3'd2,
    CFG_RED_THRESHOLD   = 3'd3,
    CFG_WHITE_THRESHOLD = 3'd4,
    CFG_RED_COUNT_LIMIT = 3'd5,
    CFG_FRONT_WIDTH     = 3'd6,
    CFG_SIDE_OFFSET     = 3'd7
  } cfg_idx_e;

  // Products formed by the shared multiplier.
  typedef enum logic [1:0] {
    MOP_P  = 2'd0,
    MOP_I1 = 2'd1,
    MOP_I2 = 2'd2,
    MOP_D  = 2'd3
  } mul_op_e;

  typedef struct packed {
    logic [1:0]  row_select;
    logic [7:0]  red_level;
    logic [7:0]  white_level;
    logic        last_in_row;
    logic [15:0] frame_interval;
  } in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic [8:0]         line_pixels;
    logic [8:0]         left_edge;
    logic [8:0]         right_edge;
    logic               row_empty;
    logic               maze_end;
    logic signed [31:0] drive_signal;
    logic               line_ahead;
    logic               line_left;
    logic               line_right;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      pix_en;
    logic      row_clear;
    logic      row_latch;
    logic      div_err_start;
    logic      err_latch;
    logic      acc_en;
    logic      mul_en;
    mul_op_e   mul_op;
    logic [1:0] mul_ph;
    logic      sum_en;
    logic      out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_last;
    logic row_ok;
    logic div_busy;
  } sts_t;

endpackage

[src/lrsp_div.sv]
module lrsp_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [lrsp_pkg::DIVD_W-1:0]      dividend_i,
  input  logic [lrsp_pkg::DIVS_W-1:0]      divisor_i,
  output logic                             busy_o,
  output logic [lrsp_pkg::DIVD_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(lrsp_pkg::DIVD_W + 1);

  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [lrsp_pkg::DIVD_W-1:0]     quo_q, quo_d;
  logic [lrsp_pkg::DIVS_W-1:0]     rem_q, rem_d;
  logic [lrsp_pkg::DIVS_W-1:0]     dvs_q, dvs_d;
  logic [lrsp_pkg::DIVS_W:0]       shifted;
  logic [lrsp_pkg::DIVS_W+1:0]     trial;

  // One restoring step per cycle, most significant quotient bit first.
  always_comb begin
    shifted = {rem_q, quo_q[lrsp_pkg::DIVD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_q};
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      cnt_d = CNT_W'(lrsp_pkg::DIVD_W);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!trial[lrsp_pkg::DIVS_W+1]) begin
        rem_d = trial[lrsp_pkg::DIVS_W-1:0];
        quo_d = {quo_q[lrsp_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[lrsp_pkg::DIVS_W-1:0];
        quo_d = {quo_q[lrsp_pkg::DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

[src/lrsp_ctrl.sv]
module lrsp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  lrsp_pkg::sts_t   sts_i,
  output lrsp_pkg::cmd_t   cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_START = 8'b0000_0010,
    ST_DIVE  = 8'b0000_0100,
    ST_ERR   = 8'b0000_1000,
    ST_ACC   = 8'b0001_0000,
    ST_MUL   = 8'b0010_0000,
    ST_SUM   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  lrsp_pkg::mul_op_e   op_q, op_d;
  logic [1:0]          ph_q, ph_d;
  logic                ovalid_q, ovalid_d;
  logic                accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;

  // Sequencing of one row close: error scaling, totals, products, sum, result.
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    ph_d     = ph_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.mul_op = op_q;
    cmd_o.mul_ph = ph_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.pix_en = 1'b1;
          if (sts_i.in_last) begin
            if (sts_i.row_ok) begin
              cmd_o.row_latch = 1'b1;
              state_d = ST_START;
            end else begin
              cmd_o.row_clear = 1'b1;
            end
          end
        end
      end
      ST_START: begin
        cmd_o.div_err_start = 1'b1;
        state_d = ST_DIVE;
      end
      ST_DIVE: begin
        if (!sts_i.div_busy) begin
          state_d = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd_o.err_latch = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        op_d  = lrsp_pkg::MOP_P;
        ph_d  = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        // The derivative product waits for the interval divide.
        if (!(op_q == lrsp_pkg::MOP_D && sts_i.div_busy)) begin
          cmd_o.mul_en = 1'b1;
          if (ph_q == 2'd2) begin
            ph_d = '0;
            if (op_q == lrsp_pkg::MOP_D) begin
              state_d = ST_SUM;
            end else begin
              op_d = lrsp_pkg::mul_op_e'(op_q + 2'd1);
            end
          end else begin
            ph_d = ph_q + 2'd1;
          end
        end
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.row_clear = 1'b1;
          ovalid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= lrsp_pkg::MOP_P;
      ph_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      ph_q     <= ph_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

[src/lrsp_dp.sv]
module lrsp_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lrsp_pkg::CFG_AW-1:0]      cfg_addr_i,
  input  logic [lrsp_pkg::CFG_DW-1:0]      cfg_wdata_i,
  input  lrsp_pkg::in_t                    in_data_i,
  output lrsp_pkg::out_t                   out_data_o,
  input  lrsp_pkg::cmd_t                   cmd_i,
  output lrsp_pkg::sts_t                   sts_o
);

  localparam int unsigned CW = lrsp_pkg::COL_W;
  localparam int unsigned RC = lrsp_pkg::ROW_COUNT;
  localparam logic [CW-1:0] WIDTH_C  = CW'(lrsp_pkg::ROW_WIDTH);
  localparam logic [CW-1:0] CENTER_C = CW'(lrsp_pkg::CENTER);

  // Configuration registers.
  logic signed [15:0] gain_p_q, gain_i_q, gain_d_q;
  logic [7:0]         red_thr_q, white_thr_q;
  logic [8:0]         red_lim_q, front_w_q, side_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      red_thr_q   <= 8'd127;
      white_thr_q <= 8'd100;
      red_lim_q   <= 9'd250;
      front_w_q   <= 9'd20;
      side_off_q  <= 9'd80;
    end else if (cfg_we_i) begin
      case (lrsp_pkg::cfg_idx_e'(cfg_addr_i))
        lrsp_pkg::CFG_GAIN_P:          gain_p_q    <= cfg_wdata_i;
        lrsp_pkg::CFG_GAIN_I:          gain_i_q    <= cfg_wdata_i;
        lrsp_pkg::CFG_GAIN_D:          gain_d_q    <= cfg_wdata_i;
        lrsp_pkg::CFG_RED_THRESHOLD:   red_thr_q   <= cfg_wdata_i[7:0];
        lrsp_pkg::CFG_WHITE_THRESHOLD: white_thr_q <= cfg_wdata_i[7:0];
        lrsp_pkg::CFG_RED_COUNT_LIMIT: red_lim_q   <= cfg_wdata_i[8:0];
        lrsp_pkg::CFG_FRONT_WIDTH:     front_w_q   <= cfg_wdata_i[8:0];
        lrsp_pkg::CFG_SIDE_OFFSET:     side_off_q  <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // Row accumulators.
  logic [CW-1:0]      col_q, col_d, white_q, white_d, red_q, red_d;
  logic [CW-1:0]      left_q, left_d, right_q, right_d;
  logic signed [15:0] osum_q, osum_d;
  logic               is_white, is_red;

  assign is_white = (in_data_i.white_level > white_thr_q);
  assign is_red   = (in_data_i.red_level > red_thr_q);

  always_comb begin
    col_d   = col_q;
    white_d = white_q;
    red_d   = red_q;
    left_d  = left_q;
    right_d = right_q;
    osum_d  = osum_q;
    if (cmd_i.row_clear) begin
      col_d   = '0;
      white_d = '0;
      red_d   = '0;
      left_d  = WIDTH_C;
      right_d = '0;
      osum_d  = '0;
    end else if (cmd_i.pix_en && col_q < WIDTH_C) begin
      col_d = col_q + 1'b1;
      if (is_red) begin
        red_d = red_q + 1'b1;
      end
      if (is_white) begin
        white_d = white_q + 1'b1;
        osum_d  = osum_q + $signed(16'(col_q)) - $signed(16'(CENTER_C));
        if (left_q == WIDTH_C) begin
          left_d = col_q;
        end
        right_d = col_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      white_q <= '0;
      red_q   <= '0;
      left_q  <= WIDTH_C;
      right_q <= '0;
      osum_q  <= '0;
    end else begin
      col_q   <= col_d;
      white_q <= white_d;
      red_q   <= red_d;
      left_q  <= left_d;
      right_q <= right_d;
      osum_q  <= osum_d;
    end
  end

  // Row being closed and its frame interval.
  logic [lrsp_pkg::ROW_W-1:0] row_q;
  logic [15:0]                dt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_latch) begin
      row_q <= in_data_i.row_select;
      dt_q  <= in_data_i.frame_interval;
    end
  end

  // Per-row state.
  logic signed [47:0] tot_q [RC];
  logic signed [31:0] prev_q [RC];
  logic [CW-1:0]      ledge_q [RC];
  logic [CW-1:0]      redge_q [RC];

  // Error scaling by reciprocal multiplication; the sum magnitude stays below 2^14.
  logic signed [31:0] err_q;
  logic signed [31:0] err_mag;
  logic [15:0]        osum_mag;
  logic [26:0]        esc_y;
  logic [54:0]        esc_q;
  logic               osum_neg_q;

  assign osum_mag = osum_q[15] ? 16'(-osum_q) : 16'(osum_q);
  assign esc_y    = {osum_mag[13:0], 13'b0} + 27'(lrsp_pkg::ERR_ROUND);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_err_start) begin
      esc_q      <= esc_y * lrsp_pkg::ERR_RECIP;
      osum_neg_q <= osum_q[15];
    end
  end

  assign err_mag = $signed(32'(esc_q[54:lrsp_pkg::ERR_SHIFT]));

  // Signed error from the scaled magnitude.
  always_ff @(posedge clk_i) begin
    if (cmd_i.err_latch) begin
      err_q <= osum_neg_q ? -err_mag : err_mag;
    end
  end

  // Interval divider for the derivative term.
  logic                           div_busy;
  logic [lrsp_pkg::DIVD_W-1:0]    div_dvd, div_quo;
  logic [lrsp_pkg::DIVS_W-1:0]    div_dvs;
  logic signed [32:0]             ediff;
  logic [32:0]                    ediff_mag;
  logic                           dneg_q;

  assign ediff     = 33'(err_q) - 33'(prev_q[row_q]);
  assign ediff_mag = ediff[32] ? 33'(-ediff) : 33'(ediff);
  // The error difference stays well below 2^24.
  assign div_dvd   = {ediff_mag[23:0], 16'b0};
  assign div_dvs   = dt_q;

  lrsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.acc_en),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      dneg_q <= ediff[32];
    end
  end

  // Saturating error total and stored edges for the closed row.
  logic signed [48:0] tot_sum;
  logic signed [47:0] tot_new;

  assign tot_sum = 49'(tot_q[row_q]) + 49'(err_q);
  always_comb begin
    if (tot_sum[48] != tot_sum[47]) begin
      tot_new = tot_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      tot_new = tot_sum[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RC; k++) begin
        tot_q[k]   <= '0;
        prev_q[k]  <= '0;
        ledge_q[k] <= WIDTH_C;
        redge_q[k] <= '0;
      end
    end else if (cmd_i.acc_en) begin
      tot_q[row_q]   <= tot_new;
      prev_q[row_q]  <= err_q;
      ledge_q[row_q] <= left_q;
      redge_q[row_q] <= right_q;
    end
  end

  // Shared 25x17 multiplier: low half, then high half of a 48-bit operand.
  logic signed [47:0] t_q, t2;
  logic signed [47:0] mx;
  logic signed [16:0] mb;
  logic signed [24:0] ma;
  logic signed [41:0] prod_q, lo_q;
  logic signed [65:0] mres, mres_s8, mres_s16;
  logic signed [49:0] p_q, i_q, d_q;
  logic [47:0]        quo_mag;

  assign quo_mag = 48'(div_quo);
  assign t2 = (dt_q == '0) ? '0 : (dneg_q ? -$signed(quo_mag) : $signed(quo_mag));

  always_comb begin
    case (cmd_i.mul_op)
      lrsp_pkg::MOP_P:  begin mx = 48'(err_q);   mb = 17'(gain_p_q); end
      lrsp_pkg::MOP_I1: begin mx = tot_q[row_q]; mb = 17'(gain_i_q); end
      lrsp_pkg::MOP_I2: begin mx = t_q;          mb = $signed({1'b0, dt_q}); end
      default:          begin mx = t2;           mb = 17'(gain_d_q); end
    endcase
    ma = (cmd_i.mul_ph == 2'd0) ? $signed({1'b0, mx[23:0]}) : 25'($signed(mx[47:24]));
  end

  assign mres     = $signed({prod_q, 24'b0}) + 66'(lo_q);
  assign mres_s8  = mres >>> 8;
  assign mres_s16 = mres >>> 16;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= ma * mb;
      if (cmd_i.mul_ph == 2'd1) begin
        lo_q <= prod_q;
      end
      if (cmd_i.mul_ph == 2'd2) begin
        case (cmd_i.mul_op)
          lrsp_pkg::MOP_P:  p_q <= mres_s8[49:0];
          lrsp_pkg::MOP_I1: begin
            if (mres_s8[65:47] != {19{mres_s8[47]}}) begin
              t_q <= mres_s8[65] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
            end else begin
              t_q <= mres_s8[47:0];
            end
          end
          lrsp_pkg::MOP_I2: i_q <= mres_s16[49:0];
          default:          d_q <= mres_s8[49:0];
        endcase
      end
    end
  end

  // Saturated drive.
  logic signed [51:0] dsum;
  logic signed [31:0] drive_q;

  assign dsum = 52'(p_q) + 52'(i_q) + 52'(d_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      if (dsum[51:31] != {21{dsum[31]}}) begin
        drive_q <= dsum[51] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end else begin
        drive_q <= dsum[31:0];
      end
    end
  end

  // Line flags from the first three rows' edges.
  logic              ahead, lflag, rflag;
  logic signed [11:0] span, lmid, lref, rmid, rref;

  always_comb begin
    span  = $signed(12'(redge_q[0])) - $signed(12'(ledge_q[0]));
    ahead = span > $signed(12'(front_w_q));
    lmid  = $signed(12'((10'(ledge_q[0]) + 10'(ledge_q[2])) >> 1));
    lref  = $signed(12'(ledge_q[1])) + $signed(12'(side_off_q));
    lflag = (ledge_q[0] != WIDTH_C) && (ledge_q[2] != WIDTH_C) && (lmid > lref);
    rmid  = $signed(12'((10'(redge_q[0]) + 10'(redge_q[2])) >> 1));
    rref  = $signed(12'(redge_q[1])) - $signed(12'(side_off_q));
    rflag = (redge_q[0] != '0) && (redge_q[2] != '0) && (rmid < rref);
  end

  // Result register.
  lrsp_pkg::out_t out_q;
  logic           last_row;

  assign last_row = (row_q == lrsp_pkg::ROW_W'(RC - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.row_index    <= row_q;
      out_q.line_pixels  <= white_q;
      out_q.left_edge    <= left_q;
      out_q.right_edge   <= right_q;
      out_q.row_empty    <= (white_q == '0);
      out_q.maze_end     <= (red_q > red_lim_q);
      out_q.drive_signal <= drive_q;
      out_q.line_ahead   <= last_row && ahead;
      out_q.line_left    <= last_row && lflag;
      out_q.line_right   <= last_row && rflag;
    end
  end

  assign out_data_o      = out_q;
  assign sts_o.in_last   = in_data_i.last_in_row;
  assign sts_o.row_ok    = (in_data_i.row_select < lrsp_pkg::ROW_W'(RC));
  assign sts_o.div_busy  = div_busy;

endmodule

[src/line_row_scan_pid.sv]
// Channel   Signals                         Direction
// in        in_valid_i/in_ready_o/in_data_i  pixel requests in
// out       out_valid_o/out_ready_i/out_data_o  row results out
// cfg       cfg_we_i/cfg_addr_i/cfg_wdata_i  register writes in
//
// A pixel that does not close a valid row leaves the input ready for the next pixel.
// A closing pixel of a valid row holds the input until its result is loaded:
// START, DIVE and ERR scale and latch the error, ACC updates the totals and starts
// the interval divide, the P, I1 and I2 products run under it, then the D product,
// the sum and the result load; the load waits while the previous result is unread.
// Reset is asynchronous, active low; all row state returns to its empty value.
module line_row_scan_pid (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  lrsp_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output lrsp_pkg::out_t                   out_data_o,
  input  logic                             cfg_we_i,
  input  logic [lrsp_pkg::CFG_AW-1:0]      cfg_addr_i,
  input  logic [lrsp_pkg::CFG_DW-1:0]      cfg_wdata_i
);

  lrsp_pkg::cmd_t cmd;
  lrsp_pkg::sts_t sts;

  // Sequencer.
  lrsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Accumulators, arithmetic and result register.
  lrsp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // The divider is idle whenever pixels are taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !sts.div_busy)
    else $error("pixel taken while divider busy");

  // A result always names a valid row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.row_index < 2'(lrsp_pkg::ROW_COUNT)))
    else $error("result row out of range");

  // The empty flag agrees with the pixel count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.row_empty == (out_data_o.line_pixels == '0)))
    else $error("row empty flag mismatch");

  // A new result is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten");

endmodule

[tb/sv/tb_line_row_scan_pid.sv]
`timescale 1ns / 1ps

module tb_line_row_scan_pid;

  localparam longint S48_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48_LO = -S48_HI - 1;
  localparam longint S32_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32_LO = -S32_HI - 1;
  localparam int     SETTLE = 200;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  lrsp_pkg::in_t                 in_data_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  lrsp_pkg::out_t                out_data_o;
  logic                          cfg_we_i = 1'b0;
  logic [lrsp_pkg::CFG_AW-1:0]   cfg_addr_i = '0;
  logic [lrsp_pkg::CFG_DW-1:0]   cfg_wdata_i = '0;

  line_row_scan_pid u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Scanner model state: register copies, the open row and per-row history.
  longint      m_gain_p, m_gain_i, m_gain_d;
  int unsigned m_red_thr, m_white_thr, m_red_limit, m_front_w, m_side_off;
  int unsigned m_col, m_whites, m_reds, m_first, m_last;
  int          m_offset;
  longint      m_err_total [lrsp_pkg::ROW_COUNT];
  longint      m_prev_err [lrsp_pkg::ROW_COUNT];
  longint      m_left_at [lrsp_pkg::ROW_COUNT];
  longint      m_right_at [lrsp_pkg::ROW_COUNT];

  lrsp_pkg::out_t row_results_q[$];
  int   fail_count = 0;
  int   pixels_sent = 0;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;

  typedef struct {
    lrsp_pkg::in_t  px;
    bit             typed;
    lrsp_pkg::out_t res;
  } pixel_case_t;

  pixel_case_t dir_tab [16];

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint fdiv(longint x, longint d);
    longint q;
    q = x / d;
    if (x % d != 0 && x < 0) q--;
    return q;
  endfunction

  task automatic open_row_clear();
    m_col = 0; m_offset = 0; m_whites = 0; m_reds = 0;
    m_first = lrsp_pkg::ROW_WIDTH; m_last = 0;
  endtask

  task automatic scanner_reset();
    m_gain_p = 0; m_gain_i = 0; m_gain_d = 0;
    m_red_thr = 127; m_white_thr = 100; m_red_limit = 250;
    m_front_w = 20; m_side_off = 80;
    open_row_clear();
    for (int k = 0; k < lrsp_pkg::ROW_COUNT; k++) begin
      m_err_total[k] = 0; m_prev_err[k] = 0;
      m_left_at[k] = lrsp_pkg::ROW_WIDTH; m_right_at[k] = 0;
    end
  endtask

  // Advance the scanner by one pixel; a closing pixel of a valid row yields a result.
  task automatic scan_pixel(input lrsp_pkg::in_t px, output bit made,
                            output lrsp_pkg::out_t r);
    longint mag, err, p, ip, dp, t, drv, dt;
    int unsigned row;
    bit ahead, lft, rgt;
    made = 1'b0; r = '0;
    ahead = 1'b0; lft = 1'b0; rgt = 1'b0;
    row = 32'(px.row_select);
    dt = 64'(px.frame_interval);
    if (m_col < lrsp_pkg::ROW_WIDTH) begin
      if (px.red_level > m_red_thr) m_reds++;
      if (px.white_level > m_white_thr) begin
        m_offset += int'(m_col) - int'(lrsp_pkg::CENTER);
        m_whites++;
        if (m_first == lrsp_pkg::ROW_WIDTH) m_first = m_col;
        m_last = m_col;
      end
      m_col++;
    end
    if (!px.last_in_row) return;
    if (row >= lrsp_pkg::ROW_COUNT) begin
      open_row_clear();
      return;
    end
    mag = m_offset < 0 ? -longint'(m_offset) : longint'(m_offset);
    mag = (mag * 65536 + 500) / 1000;
    err = clamp(m_offset < 0 ? -mag : mag, S32_LO, S32_HI);
    p = fdiv(err * m_gain_p, 256);
    m_err_total[row] = clamp(m_err_total[row] + err, S48_LO, S48_HI);
    t = clamp(fdiv(m_err_total[row] * m_gain_i, 256), S48_LO, S48_HI);
    ip = fdiv(t * dt, 65536);
    if (dt != 0) begin
      t = clamp(((err - m_prev_err[row]) * 65536) / dt, S48_LO, S48_HI);
      dp = fdiv(t * m_gain_d, 256);
    end else begin
      dp = 0;
    end
    m_prev_err[row] = err;
    drv = clamp(p + ip + dp, S32_LO, S32_HI);
    m_left_at[row] = m_first;
    m_right_at[row] = m_last;
    if (row == lrsp_pkg::ROW_COUNT - 1) begin
      ahead = (m_right_at[0] - m_left_at[0]) > longint'(m_front_w);
      if (m_left_at[0] != lrsp_pkg::ROW_WIDTH && m_left_at[2] != lrsp_pkg::ROW_WIDTH)
        lft = (m_left_at[0] + m_left_at[2]) / 2 > m_left_at[1] + longint'(m_side_off);
      if (m_right_at[0] != 0 && m_right_at[2] != 0)
        rgt = (m_right_at[0] + m_right_at[2]) / 2 < m_right_at[1] - longint'(m_side_off);
    end
    r.row_index    = row[1:0];
    r.line_pixels  = m_whites[8:0];
    r.left_edge    = m_first[8:0];
    r.right_edge   = m_last[8:0];
    r.row_empty    = (m_whites == 0);
    r.maze_end     = (m_reds > m_red_limit);
    r.drive_signal = drv[31:0];
    r.line_ahead   = ahead;
    r.line_left    = lft;
    r.line_right   = rgt;
    made = 1'b1;
    open_row_clear();
  endtask

  // Register write, mirrored into the scanner model.
  task automatic write_reg(input lrsp_pkg::cfg_idx_e idx, input logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lrsp_pkg::CFG_GAIN_P:          m_gain_p = longint'($signed(v));
      lrsp_pkg::CFG_GAIN_I:          m_gain_i = longint'($signed(v));
      lrsp_pkg::CFG_GAIN_D:          m_gain_d = longint'($signed(v));
      lrsp_pkg::CFG_RED_THRESHOLD:   m_red_thr = 32'(v[7:0]);
      lrsp_pkg::CFG_WHITE_THRESHOLD: m_white_thr = 32'(v[7:0]);
      lrsp_pkg::CFG_RED_COUNT_LIMIT: m_red_limit = 32'(v[8:0]);
      lrsp_pkg::CFG_FRONT_WIDTH:     m_front_w = 32'(v[8:0]);
      lrsp_pkg::CFG_SIDE_OFFSET:     m_side_off = 32'(v[8:0]);
      default: ;
    endcase
  endtask

  task automatic set_phase(input logic [15:0] gp, gi, gd, rt, wt, rl, fw, so);
    write_reg(lrsp_pkg::CFG_GAIN_P, gp);
    write_reg(lrsp_pkg::CFG_GAIN_I, gi);
    write_reg(lrsp_pkg::CFG_GAIN_D, gd);
    write_reg(lrsp_pkg::CFG_RED_THRESHOLD, rt);
    write_reg(lrsp_pkg::CFG_WHITE_THRESHOLD, wt);
    write_reg(lrsp_pkg::CFG_RED_COUNT_LIMIT, rl);
    write_reg(lrsp_pkg::CFG_FRONT_WIDTH, fw);
    write_reg(lrsp_pkg::CFG_SIDE_OFFSET, so);
  endtask

  // Present one pixel request and hold it until taken; called at a rising edge.
  task automatic send_pixel(input lrsp_pkg::in_t px, input bit typed,
                            input lrsp_pkg::out_t typed_res);
    bit             made;
    lrsp_pkg::out_t r;
    int             gap;
    in_valid_i <= 1'b1;
    in_data_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
    scan_pixel(px, made, r);
    if (made) row_results_q.push_back(typed ? typed_res : r);
    pixels_sent++;
    gap = tx_calm ? 0 : int'($urandom_range(16, 0));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait for the block to drain before touching the registers.
  task automatic drain();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (row_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One scan row: a white band or white noise, an optional red flood, a random close.
  task automatic send_row(input int unsigned row, input int unsigned len);
    lrsp_pkg::in_t  px;
    lrsp_pkg::out_t none;
    int unsigned a, b, dtm;
    bit   flood, noisy;
    none = '0;
    a = $urandom_range(len - 1, 0);
    b = $urandom_range(len - 1, a);
    flood = ($urandom_range(9, 0) == 0);
    noisy = ($urandom_range(4, 0) == 0);
    dtm = $urandom_range(7, 0);
    for (int unsigned c = 0; c < len; c++) begin
      px.row_select = 2'($urandom_range(3, 0));
      px.last_in_row = (c == len - 1);
      if (px.last_in_row) px.row_select = row[1:0];
      if ((c >= a && c <= b && !noisy) || (noisy && $urandom_range(1, 0)))
        px.white_level = 8'(m_white_thr < 255 ? $urandom_range(255, m_white_thr + 1) : 255);
      else
        px.white_level = 8'($urandom_range(m_white_thr, 0));
      if (flood)
        px.red_level = 8'(m_red_thr < 255 ? $urandom_range(255, m_red_thr + 1) : 255);
      else
        px.red_level = 8'($urandom_range(255, 0));
      case (dtm)
        0:       px.frame_interval = 16'd0;
        1:       px.frame_interval = 16'hFFFF;
        2:       px.frame_interval = 16'($urandom_range(16, 1));
        default: px.frame_interval = 16'($urandom_range(65535, 0));
      endcase
      send_pixel(px, 1'b0, none);
    end
  endtask

  task automatic random_phase(input int target);
    int start, row, len, pick;
    start = pixels_sent;
    row = 0;
    while (pixels_sent - start < target) begin
      if ($urandom_range(15, 0) == 0) begin
        tx_calm = 1'($urandom_range(1, 0));
        rx_calm = 1'($urandom_range(1, 0));
      end
      pick = int'($urandom_range(99, 0));
      if (pick < 70)      len = int'($urandom_range(24, 1));
      else if (pick < 94) len = int'($urandom_range(120, 25));
      else                len = int'($urandom_range(330, 300));
      send_row($urandom_range(9, 0) == 0 ? $urandom_range(3, 0) : row, len);
      row = (row + 1) % int'(lrsp_pkg::ROW_COUNT);
    end
  endtask

  // Result checker: each row result against the oldest expectation.
  always @(posedge clk_i) begin
    lrsp_pkg::out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (row_results_q.size() == 0) begin
        $error("unexpected row result %p", out_data_o);
        fail_count++;
      end else begin
        e = row_results_q.pop_front();
        if (out_data_o.row_index != e.row_index) begin
          $error("row_index exp %0d got %0d", e.row_index, out_data_o.row_index);
          fail_count++;
        end
        if (out_data_o.line_pixels != e.line_pixels) begin
          $error("line_pixels exp %0d got %0d", e.line_pixels, out_data_o.line_pixels);
          fail_count++;
        end
        if (out_data_o.left_edge != e.left_edge) begin
          $error("left_edge exp %0d got %0d", e.left_edge, out_data_o.left_edge);
          fail_count++;
        end
        if (out_data_o.right_edge != e.right_edge) begin
          $error("right_edge exp %0d got %0d", e.right_edge, out_data_o.right_edge);
          fail_count++;
        end
        if (out_data_o.row_empty != e.row_empty) begin
          $error("row_empty exp %0d got %0d", e.row_empty, out_data_o.row_empty);
          fail_count++;
        end
        if (out_data_o.maze_end != e.maze_end) begin
          $error("maze_end exp %0d got %0d", e.maze_end, out_data_o.maze_end);
          fail_count++;
        end
        if (out_data_o.drive_signal != e.drive_signal) begin
          $error("drive_signal exp %0d got %0d", e.drive_signal, out_data_o.drive_signal);
          fail_count++;
        end
        if (out_data_o.line_ahead != e.line_ahead) begin
          $error("line_ahead exp %0d got %0d", e.line_ahead, out_data_o.line_ahead);
          fail_count++;
        end
        if (out_data_o.line_left != e.line_left) begin
          $error("line_left exp %0d got %0d", e.line_left, out_data_o.line_left);
          fail_count++;
        end
        if (out_data_o.line_right != e.line_right) begin
          $error("line_right exp %0d got %0d", e.line_right, out_data_o.line_right);
          fail_count++;
        end
      end
    end
  end

  // Result side back-pressure: a fresh stall before every result.
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = rx_calm ? 0 : int'($urandom_range(16, 0));
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Watchdog.
  initial begin
    #15ms;
    $display("tb_line_row_scan_pid: FAIL");
    $finish;
  end

  initial begin
    lrsp_pkg::out_t z;
    z = '0;
    scanner_reset();

    // Directed rows under reset settings; zero gains keep the drive at zero.
    dir_tab[0]  = '{'{2'd0, 8'd0, 8'd0, 1'b1, 16'd1}, 1'b1,
                    '{2'd0, 9'd0, 9'd320, 9'd0, 1'b1, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0}};
    dir_tab[1]  = '{'{2'd1, 8'd255, 8'd255, 1'b1, 16'hFFFF}, 1'b1,
                    '{2'd1, 9'd1, 9'd0, 9'd0, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0}};
    dir_tab[2]  = '{'{2'd2, 8'd128, 8'd101, 1'b1, 16'd0}, 1'b1,
                    '{2'd2, 9'd1, 9'd0, 9'd0, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0}};
    // A closing pixel on an out-of-range row gives nothing.
    dir_tab[3]  = '{'{2'd3, 8'd255, 8'd255, 1'b1, 16'd1}, 1'b0, z};
    // Levels exactly at the thresholds are not counted.
    dir_tab[4]  = '{'{2'd3, 8'd127, 8'd100, 1'b0, 16'd0}, 1'b0, z};
    dir_tab[5]  = '{'{2'd0, 8'd127, 8'd100, 1'b1, 16'h8000}, 1'b1,
                    '{2'd0, 9'd0, 9'd320, 9'd0, 1'b1, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0}};
    dir_tab[6]  = '{'{2'd1, 8'd0, 8'd0, 1'b0, 16'h5555}, 1'b0, z};
    dir_tab[7]  = '{'{2'd2, 8'd255, 8'd255, 1'b0, 16'hAAAA}, 1'b0, z};
    dir_tab[8]  = '{'{2'd1, 8'd200, 8'd255, 1'b1, 16'h00FF}, 1'b0, z};
    dir_tab[9]  = '{'{2'd0, 8'd0, 8'd255, 1'b0, 16'd7}, 1'b0, z};
    dir_tab[10] = '{'{2'd3, 8'd255, 8'd0, 1'b0, 16'd7}, 1'b0, z};
    dir_tab[11] = '{'{2'd3, 8'd0, 8'd255, 1'b0, 16'd7}, 1'b0, z};
    dir_tab[12] = '{'{2'd2, 8'd0, 8'd0, 1'b1, 16'd3}, 1'b0, z};
    dir_tab[13] = '{'{2'd0, 8'd255, 8'd255, 1'b1, 16'hFF00}, 1'b0, z};
    dir_tab[14] = '{'{2'd1, 8'd0, 8'd0, 1'b1, 16'd1}, 1'b0, z};
    dir_tab[15] = '{'{2'd2, 8'd0, 8'd255, 1'b1, 16'hFFFF}, 1'b0, z};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].res);
    random_phase(250);
    drain();

    // Moderate gains, mid thresholds and narrow branch settings.
    set_phase(16'h0180, 16'h0020, 16'hFFC0, 16'd127, 16'd128, 16'd100, 16'd10, 16'd5);
    random_phase(450);
    drain();

    // Largest positive gains, lowest thresholds and limits.
    set_phase(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(400);
    drain();

    // Most negative gains, highest thresholds and limits.
    set_phase(16'h8000, 16'h8000, 16'h8000, 16'd255, 16'd255, 16'd320, 16'd320, 16'd320);
    random_phase(350);
    drain();

    // Random settings.
    set_phase(16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
              16'($urandom_range(65535, 0)), 16'($urandom_range(255, 0)),
              16'($urandom_range(200, 20)), 16'($urandom_range(320, 0)),
              16'($urandom_range(320, 0)), 16'($urandom_range(100, 0)));
    random_phase(480);

    drain();
    if (fail_count == 0) begin
      $display("tb_line_row_scan_pid: PASS");
    end else begin
      $display("tb_line_row_scan_pid: FAIL");
    end
    $finish;
  end

endmodule

[line_row_scan_pid.f]
src/lrsp_pkg.sv
src/lrsp_div.sv
src/lrsp_ctrl.sv
src/lrsp_dp.sv
src/line_row_scan_pid.sv
tb/sv/tb_line_row_scan_pid.sv
